@@ src/indexed_list_engine_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Indexed list engine assertion macros
// Shared assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_UNIT_DEFINES_SVH
`define INDEXED_LIST_ENGINE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset only
`define ILE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define ILE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ILE_ASSERT(lbl, prop, msg)
`define ILE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ src/ile_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine package
// Transaction types, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

    localparam int ILE_CAPACITY = 256;

    typedef enum logic [2:0] {
        FUNC_APPEND = 3'd0,
        FUNC_POP    = 3'd1,
        FUNC_INSERT = 3'd2,
        FUNC_DELETE = 3'd3,
        FUNC_GET    = 3'd4,
        FUNC_LENGTH = 3'd5
    } ile_func_t;

    typedef enum logic [1:0] {
        STATUS_DONE   = 2'd0,
        STATUS_EMPTY  = 2'd1,
        STATUS_BADPOS = 2'd2,
        STATUS_FULL   = 2'd3
    } ile_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_FETCH,
        ST_MOVE,
        ST_PLACE,
        ST_FINISH
    } ile_state_t;

    typedef enum logic [1:0] {
        RD_POS,
        RD_NEXT,
        RD_PREV
    } ile_rd_sel_t;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] value;
        logic [8:0]         position;
    } ile_in_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [8:0]         entry_count;
        logic [1:0]         status;
    } ile_out_t;

    // controller -> datapath
    typedef struct packed {
        logic        load;
        logic        rd_en;
        ile_rd_sel_t rd_sel;
        logic        ptr_ld_pos;
        logic        ptr_ld_count;
        logic        ptr_inc;
        logic        ptr_dec;
        logic        wr_shift;
        logic        wr_value;
        logic        cnt_inc;
        logic        cnt_dec;
        logic        cap_read;
        logic        set_status;
        ile_status_t status_code;
        logic        emit;
    } ile_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] func;
        logic       full;
        logic       pos_ge_cnt;
        logic       pos_gt_cnt;
        logic       del_more;
        logic       ins_more;
        logic       rsp_free;
    } ile_sts_t;

endpackage

`default_nettype wire

@@ src/indexed_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine
// Bounded positional list of signed 32-bit values, one command per transaction.
// ----------------------------------------------------------------------------
// The engine holds up to CAPACITY signed values in order and answers every
// command transaction with exactly one response transaction carrying the value
// read (pop, delete, get; zero otherwise), the entry count after the command
// and a status (done, empty or not found, bad position, full). Commands run one
// at a time. Entries live in a single-port-write, single-port-read memory with
// a registered read, so insert and delete move the entries behind the position
// one at a time, a read then a write. The response sits in an output register,
// so the next command is accepted while the previous response is still
// waiting. The entry memory has no reset; of the datapath registers only the
// count and the response valid flag are cleared, and nothing below the count
// is ever read before being written, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_engine_unit #(
    parameter int CAPACITY = ile_pkg::ILE_CAPACITY
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // command channel
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire ile_pkg::ile_in_t  cmd,
    // response channel
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output ile_pkg::ile_out_t      rsp
);
    import ile_pkg::*;

    ile_ctl_t ctl;   // sequencing commands
    ile_sts_t sts;   // compare results and output-register state

    // state machine: one command at a time, stalls the command side
    // until the response has been loaded
    ile_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .ctl       (ctl),
        .sts       (sts)
    );

    // storage, count, move pointer and response register
    ile_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

`default_nettype wire

@@ src/ile_ctrl.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine controller
// Sequences checks, reads, entry moves and the response per command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ile_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    output ile_pkg::ile_ctl_t      ctl,
    input  wire ile_pkg::ile_sts_t sts
);
    import ile_pkg::*;

    ile_state_t state_reg;
    ile_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        cmd_stall  = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (sts.func)
                    FUNC_APPEND:
                    begin
                        if (sts.full)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = STATUS_FULL;
                            state_next      = ST_FINISH;
                        end
                        else
                        begin
                            ctl.ptr_ld_count = 1'b1;
                            state_next       = ST_PLACE;
                        end
                    end
                    FUNC_POP, FUNC_DELETE:
                    begin
                        if (sts.pos_ge_cnt)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = STATUS_EMPTY;
                            state_next      = ST_FINISH;
                        end
                        else
                        begin
                            ctl.rd_en      = 1'b1;
                            ctl.rd_sel     = RD_POS;
                            ctl.ptr_ld_pos = 1'b1;
                            state_next     = ST_READ;
                        end
                    end
                    FUNC_INSERT:
                    begin
                        if (sts.full)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = STATUS_FULL;
                            state_next      = ST_FINISH;
                        end
                        else if (sts.pos_gt_cnt)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = STATUS_BADPOS;
                            state_next      = ST_FINISH;
                        end
                        else
                        begin
                            ctl.ptr_ld_count = 1'b1;
                            state_next       = ST_FETCH;
                        end
                    end
                    FUNC_GET:
                    begin
                        if (sts.pos_ge_cnt)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = STATUS_BADPOS;
                            state_next      = ST_FINISH;
                        end
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = RD_POS;
                            state_next = ST_READ;
                        end
                    end
                    default:
                    begin
                        // length and unused codes: report only
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_READ:
            begin
                ctl.cap_read = 1'b1;
                state_next   = (sts.func == FUNC_GET) ? ST_FINISH : ST_FETCH;
            end
            ST_FETCH:
            begin
                if (sts.func == FUNC_INSERT)
                begin
                    if (sts.ins_more)
                    begin
                        ctl.rd_en  = 1'b1;
                        ctl.rd_sel = RD_PREV;
                        state_next = ST_MOVE;
                    end
                    else
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else if (sts.del_more)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_NEXT;
                    state_next = ST_MOVE;
                end
                else
                begin
                    ctl.cnt_dec = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_MOVE:
            begin
                ctl.wr_shift = 1'b1;
                if (sts.func == FUNC_INSERT)
                begin
                    ctl.ptr_dec = 1'b1;
                end
                else
                begin
                    ctl.ptr_inc = 1'b1;
                end
                state_next = ST_FETCH;
            end
            ST_PLACE:
            begin
                ctl.wr_value = 1'b1;
                ctl.cnt_inc  = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.rsp_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/ile_datapath.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine datapath
// Entry memory, count, pointer, command latch and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_list_engine_unit_defines.svh"

module ile_datapath #(
    parameter int CAPACITY = ile_pkg::ILE_CAPACITY
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ile_pkg::ile_in_t  cmd,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output ile_pkg::ile_out_t      rsp,
    input  wire ile_pkg::ile_ctl_t ctl,
    output ile_pkg::ile_sts_t      sts
);
    import ile_pkg::*;

    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 9) ? CW : 9;

    logic [31:0]        mem [CAPACITY];
    logic [31:0]        rd_data_reg;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [31:0]        wr_data;

    logic [2:0]         func_reg;
    logic signed [31:0] value_reg;
    logic [8:0]         pos_reg;
    logic [IW-1:0]      ptr_reg;
    logic [IW-1:0]      ptr_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic signed [31:0] result_reg;
    ile_status_t        status_reg;
    ile_out_t           rsp_reg;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;

    logic [CMPW-1:0]    pos_ext;
    logic [CMPW-1:0]    cnt_ext;
    logic [CMPW-1:0]    ptr_ext;
    logic [IW-1:0]      pos_idx;

    assign pos_ext = CMPW'(pos_reg);
    assign cnt_ext = CMPW'(count_reg);
    assign ptr_ext = CMPW'(ptr_reg);
    assign pos_idx = pos_ext[IW-1:0];

    // status toward the controller
    always_comb
    begin
        sts.func       = func_reg;
        sts.full       = (count_reg == CW'(CAPACITY));
        sts.pos_ge_cnt = (pos_ext >= cnt_ext);
        sts.pos_gt_cnt = (pos_ext > cnt_ext);
        sts.del_more   = ((CW'(ptr_reg) + CW'(1)) < count_reg);
        sts.ins_more   = (ptr_ext > pos_ext);
        sts.rsp_free   = !rsp_valid_reg || !rsp_stall;
    end

    // memory port
    always_comb
    begin
        unique case (ctl.rd_sel)
            RD_NEXT: rd_addr = ptr_reg + IW'(1);
            RD_PREV: rd_addr = ptr_reg - IW'(1);
            default: rd_addr = pos_idx;
        endcase
        wr_en   = ctl.wr_shift || ctl.wr_value;
        wr_data = ctl.wr_value ? value_reg : rd_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[ptr_reg] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // command latch and result fields
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            func_reg   <= cmd.func;
            value_reg  <= cmd.value;
            pos_reg    <= (cmd.func == FUNC_POP) ? '0 : cmd.position;
            result_reg <= '0;
            status_reg <= STATUS_DONE;
        end
        else
        begin
            if (ctl.cap_read)
            begin
                result_reg <= rd_data_reg;
            end
            if (ctl.set_status)
            begin
                status_reg <= ctl.status_code;
            end
        end
        ptr_reg <= ptr_next;
        if (ctl.emit)
        begin
            rsp_reg.read_value  <= result_reg;
            rsp_reg.entry_count <= cnt_ext[8:0];
            rsp_reg.status      <= status_reg;
        end
    end

    always_comb
    begin
        priority if (ctl.ptr_ld_pos)
        begin
            ptr_next = pos_idx;
        end
        else if (ctl.ptr_ld_count)
        begin
            ptr_next = count_reg[IW-1:0];
        end
        else if (ctl.ptr_inc)
        begin
            ptr_next = ptr_reg + IW'(1);
        end
        else if (ctl.ptr_dec)
        begin
            ptr_next = ptr_reg - IW'(1);
        end
        else
        begin
            ptr_next = ptr_reg;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
        rsp_valid_next = ctl.emit || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ILE_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY), "count above capacity")
    `ILE_ASSERT(a_count_step,
        (count_reg == $past(count_reg)) || (count_reg - $past(count_reg) == CW'(1))
            || ($past(count_reg) - count_reg == CW'(1)),
        "count moved by more than one")
    `ILE_ASSERT(a_write_in_range,
        wr_en |-> ({1'b0, ptr_reg} < (IW+1)'(CAPACITY)),
        "write beyond capacity")
    `ILE_ASSERT(a_emit_count,
        ctl.emit |=> (rsp_valid && rsp.entry_count == cnt_ext[8:0]),
        "response count mismatch")

endmodule

`default_nettype wire
